>>> rtl/core/pqls_pkg.sv
// ----------------------------------------------------------------------------
// pqls_pkg
// Shared types and constants of the linear-scan priority queue.
// ----------------------------------------------------------------------------
package pqls_pkg;

  localparam int unsigned PQ_CAPACITY = 16;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned OCC_W       = 5;

  typedef enum logic {
    REQ_ENQ = 1'b0,
    REQ_DEQ = 1'b1
  } req_type_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic                     req_type;
    logic signed [DATA_W-1:0] item_value;
    logic signed [DATA_W-1:0] item_priority;
  } req_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] removed_value;
    logic signed [DATA_W-1:0] removed_priority;
    logic [OCC_W-1:0]         occupancy;
  } rsp_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] prio;
  } entry_t;

endpackage

>>> rtl/core/pqls_store.sv
// ----------------------------------------------------------------------------
// pqls_store
// Entry memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pqls_store
  import pqls_pkg::*;
#(
  parameter int unsigned DEPTH = PQ_CAPACITY,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  entry_t        wr_data_i,
  input  logic [AW-1:0] rd_addr_i,
  output entry_t        rd_data_o
);

  entry_t mem [DEPTH];
  entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> rtl/core/priority_queue_linear_scan.sv
// ----------------------------------------------------------------------------
// priority_queue_linear_scan
// Bounded priority queue over an unsorted entry memory, served by a scan.
//
// A request beat is taken at a clock edge with start high and busy low.
// Enqueue appends the pair; on a full queue it is dropped with status full.
// Dequeue reads every held entry through one compare unit, picks the largest
// signed priority (oldest wins a tie), then closes the gap one entry a cycle.
// Each beat gives exactly one result, shown on rsp_o for one cycle with
// done_o high; the receiver cannot stall it and must take it then.
// Enqueue and dequeue on empty give the result in the cycle after the
// request and keep busy low. A dequeue on a held queue scans every entry,
// then shifts each entry behind the winner down by one, and gives the
// result when the shift is through; the single memory read port and the
// shared compare make both serial. busy is high for the whole dequeue.
// Reset empties the queue; the entry memory needs no clearing.
// ----------------------------------------------------------------------------
module priority_queue_linear_scan
  import pqls_pkg::*;
#(
  parameter int unsigned CAPACITY = PQ_CAPACITY
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic done_o,
  output rsp_t rsp_o
);

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT
  } state_e;

  state_e          state_q;
  logic [CW-1:0]   count_q;
  logic [CW-1:0]   ptr_q;
  logic            pend_q;
  logic [CW-1:0]   pidx_q;
  logic [CW-1:0]   best_idx_q;
  entry_t          best_q;
  logic            done_q;
  rsp_t            rsp_q;

  logic            wr_en;
  logic [IW-1:0]   wr_addr;
  entry_t          wr_data;
  entry_t          rd_data;
  logic            take_best;
  logic            last_cmp;
  logic [CW-1:0]   nb_idx;
  logic            full;

  assign full      = (count_q == CW'(CAPACITY));
  assign take_best = pend_q && ((pidx_q == '0) || (rd_data.prio > best_q.prio));
  assign last_cmp  = pend_q && (pidx_q == count_q - CW'(1));
  assign nb_idx    = take_best ? pidx_q : best_idx_q;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count_q[IW-1:0];
    wr_data = '{value: req_i.item_value, prio: req_i.item_priority};
    unique case (state_q)
      S_IDLE: begin
        if (start && (req_i.req_type == REQ_ENQ) && !full) begin
          wr_en = 1'b1;
        end
      end
      S_SHIFT: begin
        if (pend_q) begin
          wr_en   = 1'b1;
          wr_addr = IW'(pidx_q - CW'(1));
          wr_data = rd_data;
        end
      end
      default: ;
    endcase
  end

  pqls_store #(
    .DEPTH (CAPACITY)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (ptr_q[IW-1:0]),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      count_q    <= '0;
      ptr_q      <= '0;
      pend_q     <= 1'b0;
      pidx_q     <= '0;
      best_idx_q <= '0;
      best_q     <= '0;
      done_q     <= 1'b0;
      rsp_q      <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start) begin
            if (req_i.req_type == REQ_ENQ) begin
              done_q                 <= 1'b1;
              rsp_q.removed_value    <= '0;
              rsp_q.removed_priority <= '0;
              if (full) begin
                rsp_q.status    <= ST_FULL;
                rsp_q.occupancy <= OCC_W'(count_q);
              end else begin
                rsp_q.status    <= ST_DONE;
                rsp_q.occupancy <= OCC_W'(count_q + CW'(1));
                count_q         <= count_q + CW'(1);
              end
            end else if (count_q == '0) begin
              done_q                 <= 1'b1;
              rsp_q.status           <= ST_EMPTY;
              rsp_q.removed_value    <= '0;
              rsp_q.removed_priority <= '0;
              rsp_q.occupancy        <= '0;
            end else begin
              state_q <= S_SCAN;
              ptr_q   <= '0;
              pend_q  <= 1'b0;
            end
          end
        end
        S_SCAN: begin
          if (ptr_q != count_q) begin
            ptr_q  <= ptr_q + CW'(1);
            pend_q <= 1'b1;
            pidx_q <= ptr_q;
          end else begin
            pend_q <= 1'b0;
          end
          if (take_best) begin
            best_q     <= rd_data;
            best_idx_q <= pidx_q;
          end
          if (last_cmp) begin
            state_q <= S_SHIFT;
            ptr_q   <= nb_idx + CW'(1);
            pend_q  <= 1'b0;
          end
        end
        S_SHIFT: begin
          if (ptr_q != count_q) begin
            ptr_q  <= ptr_q + CW'(1);
            pend_q <= 1'b1;
            pidx_q <= ptr_q;
          end else begin
            pend_q                 <= 1'b0;
            count_q                <= count_q - CW'(1);
            done_q                 <= 1'b1;
            rsp_q.status           <= ST_DONE;
            rsp_q.removed_value    <= best_q.value;
            rsp_q.removed_priority <= best_q.prio;
            rsp_q.occupancy        <= OCC_W'(count_q - CW'(1));
            state_q                <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule
